// ===== rtl/mmre_pkg.sv =====
// Shared types and constants of the matrix multiply row engine.
package mmre_pkg;

    // Accumulator and result width: signed Q16.24.
    localparam int ACC_BITS = 40;

    // Fixed widths of the transaction fields.
    localparam int ROW_FIELD_W = 6;
    localparam int COL_FIELD_W = 4;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam int INNER_LEN_W = 7;
    localparam int OUT_COLS_W  = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_INNER_LEN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_COLS  = 1'b1;

    // Request codes.
    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_STREAM = 1'b1;

    // Broadcast control from the sequencer to every column cell.
    typedef struct packed {
        logic rd;     // read the weight at the current inner position
        logic mul;    // multiply the read weight by the left element
        logic acc;    // add the product into the accumulator
        logic close;  // the element closes a row: capture and clear
        logic shift;  // move the captured results one cell toward the output
    } t_cell_ctrl;

endpackage

// ===== rtl/mmre_col_cell.sv =====
// One column cell: weight column memory, multiplier, accumulator and result shift stage.
module mmre_col_cell
    import mmre_pkg::*;
#(
    parameter int DATA_BITS = 16,
    parameter int POS_W     = 6,
    parameter int DEPTH     = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_cell_ctrl                  i_ctrl,
    input  logic                        i_wr_sel,
    input  logic                        i_active,
    input  logic [POS_W-1:0]            i_wr_addr,
    input  logic [POS_W-1:0]            i_rd_addr,
    input  logic signed [DATA_BITS-1:0] i_wdata,
    input  logic signed [DATA_BITS-1:0] i_value,
    input  logic signed [ACC_BITS-1:0]  i_shift_in,
    output logic signed [ACC_BITS-1:0]  o_shift_out
);

    localparam int PROD_W = 2 * DATA_BITS;
    localparam int SUM_W  = ((PROD_W > ACC_BITS) ? PROD_W : ACC_BITS) + 1;
    localparam logic signed [SUM_W-1:0] SAT_HI =
        {{(SUM_W-ACC_BITS+1){1'b0}}, {(ACC_BITS-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO =
        {{(SUM_W-ACC_BITS+1){1'b1}}, {(ACC_BITS-1){1'b0}}};

    logic signed [DATA_BITS-1:0] r_mem [DEPTH];
    logic signed [DATA_BITS-1:0] r_rd_data;
    logic signed [PROD_W-1:0]    r_prod;
    logic signed [ACC_BITS-1:0]  r_acc;
    logic signed [ACC_BITS-1:0]  r_sh;

    logic signed [SUM_W-1:0]     sum;
    logic signed [ACC_BITS-1:0]  sat_sum;
    logic signed [ACC_BITS-1:0]  n_acc;

    always_ff @(posedge i_clk) begin
        if (i_wr_sel) begin
            r_mem[i_wr_addr] <= i_wdata;
        end
        if (i_ctrl.rd) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul) begin
            r_prod <= r_rd_data * i_value;
        end
    end

    always_comb begin
        sum = SUM_W'(r_acc) + SUM_W'(r_prod);
        if (sum > SAT_HI) begin
            sat_sum = SAT_HI[ACC_BITS-1:0];
        end else if (sum < SAT_LO) begin
            sat_sum = SAT_LO[ACC_BITS-1:0];
        end else begin
            sat_sum = sum[ACC_BITS-1:0];
        end
        n_acc = (i_ctrl.acc && i_active) ? sat_sum : r_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_ctrl.acc && i_ctrl.close) begin
            r_acc <= '0;
        end else begin
            r_acc <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.acc && i_ctrl.close) begin
            r_sh <= n_acc;
        end else if (i_ctrl.shift) begin
            r_sh <= i_shift_in;
        end
    end

    assign o_shift_out = r_sh;

endmodule

// ===== rtl/matrix_multiply_row_engine.sv =====
// Top level of the matrix multiply row engine: sequencer, cell chain and result port.
//
// Usage. A transaction is accepted at a rising edge with i_start high and o_busy low.
// With i_req_type at the load code it writes one right-matrix element at
// (i_weight_row, i_weight_col) into the weight memory of that column's cell; loads
// outside the array are dropped. With the stream code it carries one left-matrix
// element in row-major order. Every cell reads its weight for the current inner
// position and multiplies it by the broadcast element; each cell below out_cols adds
// the product into its own saturating accumulator, so one element may be accepted
// every cycle while o_busy is low. The element that closes a row (inner length
// reached) raises o_busy. After it passes the s1 and s2 pipeline registers, the
// accumulators are captured into the shift stages of the cells and cleared, and
// the results leave cell 0 one per cycle, column 0 first, each marked by o_valid
// for one cycle, with o_last on the final column. o_busy falls with the last result.
// The receiver cannot stall the result stream. Configuration writes on i_cfg_we take
// effect at once; the user must make them while idle, which the block does not enforce.
// Reset (synchronous, active low) clears the accumulators, the inner position and
// the pipeline and restores inner_len = 64 and out_cols = 16. The weight memories
// are not cleared; every weight must be loaded before an element reads it.
module matrix_multiply_row_engine
    import mmre_pkg::*;
#(
    parameter int MAX_INNER = 64,
    parameter int MAX_COLS  = 16,
    parameter int DATA_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic                        i_req_type,
    input  logic [ROW_FIELD_W-1:0]      i_weight_row,
    input  logic [COL_FIELD_W-1:0]      i_weight_col,
    input  logic signed [DATA_BITS-1:0] i_value,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data,
    output logic                        o_valid,
    output logic [COL_FIELD_W-1:0]      o_col_index,
    output logic signed [ACC_BITS-1:0]  o_dot_value,
    output logic                        o_last
);

    localparam int POS_W = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
    localparam int IDX_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    // Configuration registers.
    logic [INNER_LEN_W-1:0] r_inner_len;
    logic [OUT_COLS_W-1:0]  r_out_cols;

    // Sequencer state.
    logic [POS_W-1:0]            r_pos, n_pos;
    logic                        r_busy, n_busy;
    logic                        r_s1_vld, r_s1_close;
    logic                        r_s2_vld, r_s2_close;
    logic signed [DATA_BITS-1:0] r_s1_value;
    logic                        r_drain;
    logic [IDX_W-1:0]            r_drain_idx;

    logic        accept, acc_load, acc_stream, closing, drain_end;
    logic [31:0] len32, cols32, row32, col32, pos32, idx32;
    logic [POS_W-1:0] wr_addr;
    t_cell_ctrl  ctrl;

    logic signed [ACC_BITS-1:0] chain [MAX_COLS+1];

    // Effective register values, clamped to the legal range.
    always_comb begin
        len32  = 32'(r_inner_len);
        cols32 = 32'(r_out_cols);
        if (len32 == 0) begin
            len32 = 1;
        end else if (len32 > 32'(MAX_INNER)) begin
            len32 = 32'(MAX_INNER);
        end
        if (cols32 == 0) begin
            cols32 = 1;
        end else if (cols32 > 32'(MAX_COLS)) begin
            cols32 = 32'(MAX_COLS);
        end
    end

    assign accept     = i_start && !r_busy;
    assign acc_load   = accept && (i_req_type == REQ_LOAD);
    assign acc_stream = accept && (i_req_type == REQ_STREAM);

    assign row32   = 32'(i_weight_row);
    assign col32   = 32'(i_weight_col);
    assign pos32   = 32'(r_pos);
    assign idx32   = 32'(r_drain_idx);
    assign wr_addr = row32[POS_W-1:0];

    // The row closes as soon as the next position reaches the inner length.
    assign closing   = (pos32 + 32'd1) >= len32;
    assign drain_end = r_drain && ((idx32 + 32'd1) == cols32);

    always_comb begin
        n_pos = r_pos;
        if (acc_stream) begin
            n_pos = closing ? '0 : POS_W'(pos32 + 32'd1);
        end
        n_busy = r_busy;
        if (acc_stream && closing) begin
            n_busy = 1'b1;
        end else if (drain_end) begin
            n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inner_len <= INNER_LEN_W'(64);
            r_out_cols  <= OUT_COLS_W'(16);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_INNER_LEN: r_inner_len <= i_cfg_data[INNER_LEN_W-1:0];
                CFG_OUT_COLS:  r_out_cols  <= i_cfg_data[OUT_COLS_W-1:0];
                default:       r_inner_len <= r_inner_len;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_busy      <= 1'b0;
            r_s1_vld    <= 1'b0;
            r_s1_close  <= 1'b0;
            r_s2_vld    <= 1'b0;
            r_s2_close  <= 1'b0;
            r_drain     <= 1'b0;
            r_drain_idx <= '0;
        end else begin
            r_pos      <= n_pos;
            r_busy     <= n_busy;
            r_s1_vld   <= acc_stream;
            r_s1_close <= acc_stream && closing;
            r_s2_vld   <= r_s1_vld;
            r_s2_close <= r_s1_close;
            if (r_s2_vld && r_s2_close) begin
                r_drain     <= 1'b1;
                r_drain_idx <= '0;
            end else if (drain_end) begin
                r_drain     <= 1'b0;
            end else if (r_drain) begin
                r_drain_idx <= r_drain_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_stream) begin
            r_s1_value <= i_value;
        end
    end

    assign ctrl.rd    = acc_stream;
    assign ctrl.mul   = r_s1_vld;
    assign ctrl.acc   = r_s2_vld;
    assign ctrl.close = r_s2_close;
    assign ctrl.shift = r_drain;

    // The chain of column cells; results move toward cell 0 during the drain.
    assign chain[MAX_COLS] = '0;

    for (genvar c = 0; c < MAX_COLS; c++) begin : g_cell
        mmre_col_cell #(
            .DATA_BITS (DATA_BITS),
            .POS_W     (POS_W),
            .DEPTH     (MAX_INNER)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (ctrl),
            .i_wr_sel    (acc_load && (row32 < 32'(MAX_INNER)) && (col32 == 32'(c))),
            .i_active    (cols32 > 32'(c)),
            .i_wr_addr   (wr_addr),
            .i_rd_addr   (r_pos),
            .i_wdata     (i_value),
            .i_value     (r_s1_value),
            .i_shift_in  (chain[c+1]),
            .o_shift_out (chain[c])
        );
    end

    assign o_busy      = r_busy;
    assign o_valid     = r_drain;
    assign o_col_index = idx32[COL_FIELD_W-1:0];
    assign o_dot_value = chain[0];
    assign o_last      = drain_end;

endmodule
